>>> hw/rtl/sha_pkg.sv
`default_nettype none
package sha_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
		logic       end_only;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic       store_byte;   // write byte at fill level
		logic [7:0] store_val;
		logic       store_len;    // write length word into bytes 56..63
		logic       count_byte;   // bump message length
		logic       round_start;  // load working vars from chain
		logic       round_step;   // one compression round
		logic       chain_add;    // fold working vars into chain
		logic       chain_init;   // back to initial hash, clear length
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] round;
		logic       round_done;
	} dp_sts_t;

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [6:0] LenStart = 7'd56;
	localparam logic [6:0] BlockBytes = 7'd64;

	localparam logic [31:0] HashInit [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sha_datapath.sv
`default_nettype none
module sha_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sha_pkg::dp_cmd_t  cmd,
	input  wire logic [5:0]        fill,
	input  wire logic [2:0]        rd_word,
	output sha_pkg::dp_sts_t       sts,
	output logic [31:0]            chain_word
);

	// block buffer held as sixteen schedule words; rolls as the schedule advances
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [60:0] len_q;
	logic [5:0]  round_q;
	logic        done_q;

	logic [31:0] s0, s1, w_new, big0, big1, ch, maj, t1, t2, wt;
	logic [63:0] bits;

	assign bits = {len_q, 3'b000};
	assign wt   = w_q[0];

	// next schedule word and round function
	always_comb begin
		s0    = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1    = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		big1  = sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11) ^ sha_pkg::rotr(v_q[4], 25);
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1    = v_q[7] + big1 + ch + sha_pkg::RoundK[round_q] + wt;
		big0  = sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13) ^ sha_pkg::rotr(v_q[0], 22);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2    = big0 + maj;
	end

	// buffer, schedule and working variables
	always_ff @(posedge clk) begin
		if (cmd.store_byte) begin
			unique case (fill[1:0])
				2'd0: w_q[fill[5:2]][31:24] <= cmd.store_val;
				2'd1: w_q[fill[5:2]][23:16] <= cmd.store_val;
				2'd2: w_q[fill[5:2]][15:8]  <= cmd.store_val;
				default: w_q[fill[5:2]][7:0] <= cmd.store_val;
			endcase
		end
		if (cmd.store_len) begin
			w_q[14] <= bits[63:32];
			w_q[15] <= bits[31:0];
		end
		if (cmd.round_start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end
		if (cmd.round_step) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// chain state, length and round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::HashInit[i];
			len_q   <= '0;
			round_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cmd.count_byte) len_q <= len_q + 61'd1;
			if (cmd.chain_add) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end
			if (cmd.chain_init) begin
				for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::HashInit[i];
				len_q <= '0;
			end
			done_q <= 1'b0;
			if (cmd.round_start) round_q <= '0;
			else if (cmd.round_step) begin
				round_q <= round_q + 6'd1;
				done_q  <= (round_q == 6'd63);
			end
		end
	end

	assign sts.round      = round_q;
	assign sts.round_done = done_q;
	assign chain_word     = h_q[rd_word];

endmodule
`default_nettype wire

>>> hw/rtl/sha_ctrl.sv
`default_nettype none
module sha_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire sha_pkg::in_item_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output sha_pkg::out_item_t       out_data,
	output sha_pkg::dp_cmd_t         cmd,
	input  wire sha_pkg::dp_sts_t    sts,
	output logic [5:0]               fill,
	output logic [2:0]               rd_word,
	input  wire logic [31:0]         chain_word
);

	typedef enum logic [2:0] {
		S_IDLE, S_START, S_ROUND, S_ADD, S_PAD, S_EMIT
	} state_t;

	state_t      state_q;
	logic [6:0]  fill_q;
	logic        final_q;   // compression in flight ends the message
	logic        last_q;    // message ended, padding still owed
	logic        pad_q;     // pad marker placed, zero fill in progress
	logic        lenok_q;   // length fits in the current block
	logic [2:0]  word_q;
	logic        accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign fill     = fill_q[5:0];
	assign rd_word  = word_q;

	// datapath commands
	always_comb begin
		cmd = '0;
		cmd.store_val = in_data.data_byte;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !in_data.end_only) begin
					cmd.store_byte = 1'b1;
					cmd.count_byte = 1'b1;
				end
			end
			S_START: cmd.round_start = 1'b1;
			S_ROUND: cmd.round_step  = 1'b1;
			S_ADD:   cmd.chain_add   = 1'b1;
			S_PAD: begin
				if (!pad_q) begin
					// pad marker right after the last byte
					if (fill_q != sha_pkg::BlockBytes) begin
						cmd.store_byte = 1'b1;
						cmd.store_val  = sha_pkg::PadByte;
					end
				end else if (fill_q == sha_pkg::LenStart && lenok_q) begin
					cmd.store_len = 1'b1;
				end else if (fill_q < sha_pkg::BlockBytes) begin
					cmd.store_byte = 1'b1;
					cmd.store_val  = 8'h00;
				end
			end
			S_EMIT: begin
				if (!out_stall && word_q == 3'd7) cmd.chain_init = 1'b1;
			end
			default: ;
		endcase
	end

	// control state, fill level and padding flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			final_q <= 1'b0;
			last_q  <= 1'b0;
			pad_q   <= 1'b0;
			lenok_q <= 1'b0;
			word_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!in_data.end_only) fill_q <= fill_q + 7'd1;
						if (in_data.is_last) begin
							last_q  <= 1'b1;
							pad_q   <= 1'b0;
							state_q <= S_PAD;
						end else if (!in_data.end_only && fill_q == 7'd63) begin
							fill_q  <= '0;
							state_q <= S_START;
						end
					end
				end
				S_PAD: begin
					// first pad cycle: wrap a full block or drop 0x80
					if (!pad_q) begin
						if (fill_q == sha_pkg::BlockBytes) begin
							fill_q  <= '0;
							state_q <= S_START;
						end else begin
							pad_q   <= 1'b1;
							fill_q  <= fill_q + 7'd1;
							lenok_q <= (fill_q < sha_pkg::LenStart);
						end
					end else if (fill_q == sha_pkg::LenStart && lenok_q) begin
						final_q <= 1'b1;
						fill_q  <= '0;
						state_q <= S_START;
					end else if (fill_q == sha_pkg::BlockBytes) begin
						fill_q  <= '0;
						lenok_q <= 1'b1;
						state_q <= S_START;
					end else begin
						fill_q <= fill_q + 7'd1;
					end
				end
				S_START: state_q <= S_ROUND;
				S_ROUND: if (sts.round == 6'd63) state_q <= S_ADD;
				S_ADD: begin
					if (final_q) begin
						word_q  <= '0;
						state_q <= S_EMIT;
					end else if (last_q) state_q <= S_PAD;
					else state_q <= S_IDLE;
				end
				S_EMIT: begin
					if (!out_stall) begin
						word_q <= word_q + 3'd1;
						if (word_q == 3'd7) begin
							final_q <= 1'b0;
							last_q  <= 1'b0;
							pad_q   <= 1'b0;
							lenok_q <= 1'b0;
							fill_q  <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid            = (state_q == S_EMIT);
	assign out_data.digest_word = chain_word;
	assign out_data.word_index  = word_q;
	assign out_data.last_word   = (word_q == 3'd7);

	// a full block never waits in the idle state
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> fill_q < sha_pkg::BlockBytes)
		else $error("fill level out of range while idle");
	a_round_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_START |=> state_q == S_ROUND && sts.round == 6'd0)
		else $error("compression did not start at round zero");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(word_q))
		else $error("digest word moved while stalled");

endmodule
`default_nettype wire

>>> hw/rtl/sha256_message_hasher.sv
`default_nettype none
// SHA-256 hasher taking one message byte per transfer. Every 64th byte starts
// a compression (64 rounds at one round per cycle in the single round unit,
// plus load and chain add), during which stall is high. A last item adds
// padding (one byte per cycle, the length as one 64-bit write), one or two
// compressions, then eight digest words, one per transfer, word 0 first. The
// chaining state then returns to the initial values.
module sha256_message_hasher (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire sha_pkg::in_item_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output sha_pkg::out_item_t       out_data
);

	sha_pkg::dp_cmd_t cmd;
	sha_pkg::dp_sts_t sts;
	logic [5:0]       fill;
	logic [2:0]       rd_word;
	logic [31:0]      chain_word;

	sha_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
		.out_data, .cmd, .sts, .fill, .rd_word, .chain_word
	);

	sha_datapath u_dp (
		.clk, .arst_n, .cmd, .fill, .rd_word, .sts, .chain_word
	);

endmodule
`default_nettype wire

>>> sim/tb_sha256_message_hasher.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_sha256_message_hasher;

	localparam int IdleLimit = 20000;
	localparam int HoldCycles = 400;
	localparam int DrainCycles = 200;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	sha_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	sha_pkg::out_item_t out_data;

	sha256_message_hasher uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// hasher state mirrored in the testbench
	logic [7:0] msg_block [64];
	logic [31:0] chain_words [8];
	logic [60:0] byte_count;
	int block_fill;

	sha_pkg::in_item_t pending_items [$];
	sha_pkg::out_item_t digest_queue [$];
	int error_count;
	bit sender_paused;
	bit hold_receiver;
	bit calm_phase;
	int idle_count = 0;
	int hold_count = 0;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [31:0] ror32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one 64-round compression of msg_block into chain_words
	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2, k;
		int t;
		for (t = 0; t < 16; t++)
			w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
		for (t = 16; t < 64; t++) begin
			s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = w[t-16] + s0 + w[t-7] + s1;
		end
		v = chain_words;
		for (t = 0; t < 64; t++) begin
			k = sha_pkg::RoundK[t];
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w[t];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (t = 0; t < 8; t++)
			chain_words[t] += v[t];
	endtask

	task automatic hash_init();
		chain_words = sha_pkg::HashInit;
		byte_count = '0;
		block_fill = 0;
	endtask

	// absorb one transfer; on a last item queue the eight digest words
	task automatic absorb_item(sha_pkg::in_item_t it);
		logic [63:0] bit_len;
		sha_pkg::out_item_t o;
		int i;
		if (!it.end_only) begin
			msg_block[block_fill] = it.data_byte;
			block_fill++;
			byte_count++;
			if (block_fill == 64) begin
				compress_block();
				block_fill = 0;
			end
		end
		if (it.is_last) begin
			msg_block[block_fill] = sha_pkg::PadByte;
			block_fill++;
			if (block_fill > 56) begin
				while (block_fill < 64) msg_block[block_fill++] = 8'h00;
				compress_block();
				block_fill = 0;
			end
			while (block_fill < 56) msg_block[block_fill++] = 8'h00;
			bit_len = {byte_count, 3'b000};
			for (i = 0; i < 8; i++)
				msg_block[56+i] = bit_len[8*(7-i) +: 8];
			compress_block();
			for (i = 0; i < 8; i++) begin
				o.digest_word = chain_words[i];
				o.word_index = 3'(i);
				o.last_word = (i == 7);
				digest_queue.push_back(o);
			end
			hash_init();
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
		error_count++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
	endtask

	function automatic bit coin();
		return calm_phase ? 1'b1 : ($urandom_range(99) >= 38);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall)
				absorb_item(in_data);
			if (!(in_valid && in_stall)) begin
				if (pending_items.size() > 0 && !sender_paused && coin()) begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
					in_data <= sha_pkg::in_item_t'(10'($urandom));
				end
			end
		end
	end

	// monitor and receiver stall, with the long hold counted here
	always @(posedge clk or negedge arst_n) begin
		sha_pkg::out_item_t exp;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (digest_queue.size() == 0) begin
					report_mismatch("unexpected word", out_data.digest_word, '0);
				end else begin
					exp = digest_queue.pop_front();
					if (out_data.digest_word !== exp.digest_word)
						report_mismatch("digest_word", out_data.digest_word, exp.digest_word);
					if (out_data.word_index !== exp.word_index)
						report_mismatch("word_index", out_data.word_index, exp.word_index);
					if (out_data.last_word !== exp.last_word)
						report_mismatch("last_word", out_data.last_word, exp.last_word);
				end
			end
			if (hold_receiver && hold_count < HoldCycles) begin
				hold_count <= hold_count + 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !coin();
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_count <= 0;
		end else if (idle_count >= IdleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

	task automatic push_msg(int len, int fixed);
		sha_pkg::in_item_t it;
		int i;
		for (i = 0; i < len; i++) begin
			it.data_byte = (fixed >= 0) ? 8'(fixed) : 8'($urandom);
			it.end_only = 1'b0;
			it.is_last = (i == len - 1);
			pending_items.push_back(it);
		end
		if (len == 0) begin
			it.data_byte = 8'($urandom);
			it.end_only = 1'b1;
			it.is_last = 1'b1;
			pending_items.push_back(it);
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || digest_queue.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		sha_pkg::in_item_t it;
		int n, r;
		error_count = 0;
		sender_paused = 0;
		hold_receiver = 0;
		calm_phase = 0;
		for (n = 0; n < 64; n++) msg_block[n] = '0;
		hash_init();
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty message, ignored end-only, single extremes
		push_msg(0, -1);
		it = '{data_byte: 8'hff, is_last: 1'b0, end_only: 1'b1};
		pending_items.push_back(it);
		push_msg(1, 8'h00);
		push_msg(1, 8'hff);
		// end-only that closes a nonempty message
		push_msg(2, 8'ha5);
		pending_items[pending_items.size()-1].is_last = 1'b0;
		it = '{data_byte: 8'h5a, is_last: 1'b1, end_only: 1'b1};
		pending_items.push_back(it);
		wait_drained();

		// padding boundaries in calm flow: 56 needs two blocks, 64 exact
		calm_phase = 1;
		push_msg(56, -1);
		push_msg(64, -1);
		wait_drained();
		calm_phase = 0;

		// receiver holds off while the sender keeps offering
		hold_receiver = 1;
		push_msg(3, -1);
		push_msg(0, -1);
		push_msg(5, -1);
		wait (hold_count >= HoldCycles);
		hold_receiver = 0;
		wait_drained();

		// random short messages
		for (n = 0; n < 6; n++) begin
			r = $urandom_range(99);
			if (r < 10) push_msg(0, -1);
			else push_msg($urandom_range(1, 8), -1);
			if ($urandom_range(3) == 0) begin
				it = '{data_byte: 8'($urandom), is_last: 1'b0, end_only: 1'b1};
				pending_items.insert($urandom_range(pending_items.size()), it);
			end
			if (n == 3) begin
				// sender pauses once every digest word is back
				wait_drained();
				sender_paused = 1;
				repeat ($urandom_range(5, 30)) @(posedge clk);
				sender_paused = 0;
			end
		end
		wait_drained();
		repeat (DrainCycles) @(posedge clk);

		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire
